// ===== rtl/core/mfhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_pkg
// Shared types and codes for the 802.15.4 MAC frame header parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_RSVD    = 3'd2;
  localparam logic [2:0] ST_BAD_DST = 3'd3;
  localparam logic [2:0] ST_BAD_SRC = 3'd4;
  localparam logic [2:0] ST_OTHER   = 3'd5;
  localparam logic [2:0] ST_TRUNC   = 3'd6;

  // Frame types (frame control bits 2:0)
  localparam logic [2:0] FT_DATA = 3'd1;
  localparam logic [2:0] FT_ACK  = 3'd2;

  // Address modes
  localparam logic [1:0] AM_NONE  = 2'd0;
  localparam logic [1:0] AM_RSVD  = 2'd1;
  localparam logic [1:0] AM_SHORT = 2'd2;
  localparam logic [1:0] AM_LONG  = 2'd3;

  localparam int OUT_DATA_W = 216;
  localparam int OUT_USER_W = 6;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  parse_status;
    logic [2:0]  frame_kind;
    logic [7:0]  seq_num;
    logic [15:0] pan_ident;
    logic [15:0] dest_short;
    logic [63:0] dest_long;
    logic [15:0] source_short;
    logic [63:0] source_long;
    logic        is_broadcast;
    logic [6:0]  header_bytes;
    logic [6:0]  payload_bytes;
    logic [15:0] check_word;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfhp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_in_stage
// Input register for one frame byte; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module mfhp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire mfhp_pkg::in_item_t s_item,
  input  wire logic               take,
  output logic                    item_valid,
  output mfhp_pkg::in_item_t      item
);
  import mfhp_pkg::*;

  assign s_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mfhp_parse_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_parse_core
// Per-frame header state; folds in one byte per step and forms the result.
// ----------------------------------------------------------------------------
module mfhp_parse_core #(
  parameter int MAX_FRAME_BYTES = 127
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire mfhp_pkg::in_item_t item,
  output mfhp_pkg::result_t       res
);
  import mfhp_pkg::*;

  localparam logic [7:0] MAX_POS = 8'(MAX_FRAME_BYTES);

  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] control_word, control_word_next;
  logic [7:0]  seq_reg, seq_reg_next;
  logic [15:0] pan_reg, pan_reg_next;
  logic [15:0] dst_short_reg, dst_short_reg_next;
  logic [63:0] dst_long_reg, dst_long_reg_next;
  logic [15:0] src_short_reg, src_short_reg_next;
  logic [63:0] src_long_reg, src_long_reg_next;
  logic        broadcast_flag, broadcast_flag_next;
  logic [7:0]  header_end, header_end_next;
  logic [15:0] last_two_bytes, last_two_bytes_next;
  logic [2:0]  error_code, error_code_next;

  logic [7:0]  b;
  logic [7:0]  p;
  logic [1:0]  dm, sm, dmw, smw;
  logic [2:0]  kindw;
  logic [7:0]  s0;
  logic [7:0]  dl_off, sl_off;
  logic [7:0]  pay;
  logic        trunc;

  function automatic logic [7:0] dst_len(input logic [1:0] mode, input logic bc);
    logic [7:0] n;
    begin
      case (mode)
        AM_SHORT: n = bc ? 8'd6 : 8'd4;
        AM_LONG:  n = 8'd10;
        default:  n = 8'd0;
      endcase
      return n;
    end
  endfunction

  function automatic logic [7:0] src_len(input logic [1:0] mode);
    logic [7:0] n;
    begin
      case (mode)
        AM_SHORT: n = 8'd2;
        AM_LONG:  n = 8'd8;
        default:  n = 8'd0;
      endcase
      return n;
    end
  endfunction

  always_comb begin
    byte_position_next  = byte_position;
    control_word_next   = control_word;
    seq_reg_next        = seq_reg;
    pan_reg_next        = pan_reg;
    dst_short_reg_next  = dst_short_reg;
    dst_long_reg_next   = dst_long_reg;
    src_short_reg_next  = src_short_reg;
    src_long_reg_next   = src_long_reg;
    broadcast_flag_next = broadcast_flag;
    header_end_next     = header_end;
    last_two_bytes_next = last_two_bytes;
    error_code_next     = error_code;

    b      = item.frame_byte;
    p      = byte_position;
    dm     = control_word[11:10];
    sm     = control_word[15:14];
    kindw  = 3'd0;
    dmw    = 2'd0;
    smw    = 2'd0;
    s0     = 8'd0;
    dl_off = p - 8'd5;
    sl_off = 8'd0;
    pay    = 8'd0;
    trunc  = 1'b0;
    res    = '0;

    if (p < MAX_POS) begin
      last_two_bytes_next = {b, last_two_bytes[15:8]};
      if (p == 8'd0) begin
        control_word_next = {8'h00, b};
      end else if (p == 8'd1) begin
        control_word_next = {b, control_word[7:0]};
        kindw = control_word_next[2:0];
        dmw   = control_word_next[11:10];
        smw   = control_word_next[15:14];
        if (control_word_next[7]) begin
          error_code_next = ST_RSVD;
        end else if (kindw == FT_ACK) begin
          error_code_next = ST_OK;
          header_end_next = 8'd3;
        end else if (kindw != FT_DATA) begin
          error_code_next = ST_OTHER;
        end else if (dmw == AM_RSVD) begin
          error_code_next = ST_BAD_DST;
        end else if (smw == AM_RSVD) begin
          error_code_next = ST_BAD_SRC;
        end else begin
          error_code_next = ST_OK;
          header_end_next = 8'd3 + dst_len(dmw, 1'b0) + src_len(smw);
        end
      end else if (error_code == ST_OK) begin
        if (control_word[2:0] == FT_DATA) begin
          if (p == 8'd2) begin
            seq_reg_next = b;
          end else begin
            // destination PAN always present for short/long destination
            if (dm == AM_SHORT || dm == AM_LONG) begin
              if (p == 8'd3) pan_reg_next = {8'h00, b};
              if (p == 8'd4) pan_reg_next = {b, pan_reg[7:0]};
            end
            if (dm == AM_SHORT) begin
              if (p == 8'd5) dst_short_reg_next = {8'h00, b};
              if (p == 8'd6) begin
                dst_short_reg_next = {b, dst_short_reg[7:0]};
                if (pan_reg == 16'hFFFF && dst_short_reg_next == 16'hFFFF) begin
                  broadcast_flag_next = 1'b1;
                  header_end_next     = header_end + 8'd2;
                end
              end
              // broadcast: following word replaces the PAN
              if (broadcast_flag_next) begin
                if (p == 8'd7) pan_reg_next = {8'h00, b};
                if (p == 8'd8) pan_reg_next = {b, pan_reg[7:0]};
              end
            end
            if (dm == AM_LONG && p >= 8'd5 && p <= 8'd12) begin
              dst_long_reg_next[{dl_off[2:0], 3'b000} +: 8] = b;
            end
            s0     = 8'd3 + dst_len(dm, broadcast_flag_next);
            sl_off = p - s0;
            if (p >= s0) begin
              if (sm == AM_SHORT) begin
                if (p == s0)        src_short_reg_next = {8'h00, b};
                if (p == s0 + 8'd1) src_short_reg_next = {b, src_short_reg[7:0]};
              end
              if (sm == AM_LONG && p <= s0 + 8'd7) begin
                src_long_reg_next[{sl_off[2:0], 3'b000} +: 8] = b;
              end
            end
          end
        end else if (p == 8'd2) begin
          seq_reg_next = b;
        end
      end
      byte_position_next = p + 8'd1;
    end

    // result from the updated state
    if (byte_position_next < 8'd2) begin
      res.parse_status = ST_SHORT;
    end else begin
      if (control_word_next[2:0] == FT_ACK) begin
        trunc = byte_position_next < 8'd3;
      end else begin
        trunc = {1'b0, byte_position_next} < ({1'b0, header_end_next} + 9'd2);
      end
      res.frame_kind = control_word_next[2:0];
      if (error_code_next != ST_OK) begin
        res.parse_status = error_code_next;
      end else if (trunc) begin
        res.parse_status = ST_TRUNC;
      end else begin
        res.parse_status = ST_OK;
        res.seq_num      = seq_reg_next;
        if (control_word_next[2:0] == FT_DATA) begin
          pay = byte_position_next - header_end_next - 8'd2;
          res.pan_ident     = pan_reg_next;
          res.dest_short    = dst_short_reg_next;
          res.dest_long     = broadcast_flag_next ? {64{1'b1}} : dst_long_reg_next;
          res.source_short  = src_short_reg_next;
          res.source_long   = src_long_reg_next;
          res.is_broadcast  = broadcast_flag_next;
          res.header_bytes  = header_end_next[6:0];
          res.payload_bytes = pay[7] ? 7'h7F : pay[6:0];
          res.check_word    = last_two_bytes_next;
        end
      end
    end

    // frame end clears all per-frame state
    if (item.frame_end) begin
      byte_position_next  = '0;
      control_word_next   = '0;
      seq_reg_next        = '0;
      pan_reg_next        = '0;
      dst_short_reg_next  = '0;
      dst_long_reg_next   = '0;
      src_short_reg_next  = '0;
      src_long_reg_next   = '0;
      broadcast_flag_next = 1'b0;
      header_end_next     = '0;
      last_two_bytes_next = '0;
      error_code_next     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      control_word   <= '0;
      seq_reg        <= '0;
      pan_reg        <= '0;
      dst_short_reg  <= '0;
      dst_long_reg   <= '0;
      src_short_reg  <= '0;
      src_long_reg   <= '0;
      broadcast_flag <= 1'b0;
      header_end     <= '0;
      last_two_bytes <= '0;
      error_code     <= ST_OK;
    end else if (step) begin
      byte_position  <= byte_position_next;
      control_word   <= control_word_next;
      seq_reg        <= seq_reg_next;
      pan_reg        <= pan_reg_next;
      dst_short_reg  <= dst_short_reg_next;
      dst_long_reg   <= dst_long_reg_next;
      src_short_reg  <= src_short_reg_next;
      src_long_reg   <= src_long_reg_next;
      broadcast_flag <= broadcast_flag_next;
      header_end     <= header_end_next;
      last_two_bytes <= last_two_bytes_next;
      error_code     <= error_code_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mfhp_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_out_stage
// Result register; holds one parsed header until the sink takes it.
// ----------------------------------------------------------------------------
module mfhp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire mfhp_pkg::result_t res_in,
  output logic                   free,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output mfhp_pkg::result_t      res_out
);
  import mfhp_pkg::*;

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mac_frame_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A frame's last byte goes from the input register to the result register when it is empty.
// Throughput: one frame byte per cycle; one result per frame, one per cycle for 1-byte frames,
// if the sink keeps up. The combinational header update between the registers sets this rate.
// Reset (rst, synchronous, active high) empties both registers and clears frame state.
// ----------------------------------------------------------------------------
// mac_frame_header_parser
// Receive-side 802.15.4 MAC header parser: bytes in, one decoded header out.
// ----------------------------------------------------------------------------
module mac_frame_header_parser #(
  parameter int MAX_FRAME_BYTES = 127  // bytes past this count are dropped
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // frame byte stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // frame_byte
  input  wire logic         s_axis_tlast,   // frame_end
  // parsed header stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // from bit 0: seq_num[7:0], pan_ident[15:0], dest_short[15:0],
  // dest_long[63:0], source_short[15:0], source_long[63:0], is_broadcast,
  // header_bytes[6:0], payload_bytes[6:0], check_word[15:0], one zero pad bit
  output logic [215:0]      m_axis_tdata,
  // from bit 0: parse_status[2:0], frame_kind[2:0]
  output logic [5:0]        m_axis_tuser
);
  import mfhp_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     take;
  logic     out_free;
  result_t  res_next;
  result_t  res;

  assign s_item.frame_byte = s_axis_tdata;
  assign s_item.frame_end  = s_axis_tlast;

  // A held byte advances unless it ends a frame while the result slot is busy.
  assign take = item_valid && (!item.frame_end || out_free);

  mfhp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mfhp_parse_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (item),
    .res  (res_next)
  );

  mfhp_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (take && item.frame_end),
    .res_in  (res_next),
    .free    (out_free),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .res_out (res)
  );

  // Pack fields low to high.
  assign m_axis_tdata = {1'b0,
                         res.check_word,
                         res.payload_bytes,
                         res.header_bytes,
                         res.is_broadcast,
                         res.source_long,
                         res.source_short,
                         res.dest_long,
                         res.dest_short,
                         res.pan_ident,
                         res.seq_num};

  assign m_axis_tuser = {res.frame_kind, res.parse_status};

endmodule
`default_nettype wire
